// File: rtl/core/url_path_normalizer_assert.svh
// Assertion macros used by the URL path normalizer RTL.
`ifndef URL_PATH_NORMALIZER_ASSERT_SVH
`define URL_PATH_NORMALIZER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define UPN_ASSERT_IMPLIES(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("url_path_normalizer: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define UPN_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("url_path_normalizer: next-cycle check failed");

`endif

// File: rtl/core/upn_pkg.sv
// Shared constants, types and helpers of the URL path normalizer.
package upn_pkg;

   localparam int MAX_PATH = 64;
   localparam int FILL_W   = $clog2(MAX_PATH + 1);
   localparam int ADDR_W   = $clog2(MAX_PATH);

   localparam int CQ_DEPTH = 4;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] rel;
      logic       drop;
      logic       store_ch;
      logic       slash;
      logic       qbyte;
      logic       dump;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       part;
      logic       empty_path;
      logic       overflowed;
      logic       run_end;
      logic       target_end;
   } result_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cq_head_type;

   function automatic logic has_ops(cmd_type c);
      return (c.rel != 2'd0) || c.drop || c.store_ch || c.slash || c.qbyte || c.dump;
   endfunction

endpackage

// File: rtl/core/upn_front.sv
// Front end: accepts target bytes, tracks segments and issues store, drop, query and dump commands.
module upn_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [7:0]       char_in,
   input  logic             final_in,
   input  logic             q_full,
   output logic             full,
   output logic             enq,
   output upn_pkg::cmd_type cmd
);
   import upn_pkg::*;

   logic       in_query_ff, in_query_in;
   logic [1:0] seg_len_ff, seg_len_in;
   logic       all_dots_ff, all_dots_in;
   logic [1:0] held;
   logic [1:0] len_plus;
   logic       accept;
   logic       close_drop;

   assign full     = q_full;
   assign accept   = push && !q_full;
   assign held     = (all_dots_ff && seg_len_ff != 2'd3) ? seg_len_ff : 2'd0;
   assign len_plus = seg_len_ff + 2'd1;
   assign close_drop = all_dots_ff && seg_len_ff == 2'd2;

   always_comb begin
      in_query_in = in_query_ff;
      seg_len_in  = seg_len_ff;
      all_dots_in = all_dots_ff;
      cmd         = '0;
      cmd.ch      = char_in;
      cmd.fin     = final_in;
      if (in_query_ff) begin
         cmd.qbyte = 1'b1;
      end else if (char_in == CH_QUERY || char_in == CH_SLASH) begin
         cmd.drop = close_drop;
         cmd.rel  = close_drop ? 2'd0 : held;
         if (char_in == CH_QUERY) begin
            cmd.dump    = 1'b1;
            in_query_in = 1'b1;
         end else begin
            cmd.slash = 1'b1;
            if (final_in) begin
               cmd.dump = 1'b1;
            end
         end
         seg_len_in  = 2'd0;
         all_dots_in = 1'b1;
      end else if (char_in == CH_DOT && all_dots_ff && seg_len_ff < 2'd2) begin
         seg_len_in = len_plus;
         if (final_in) begin
            cmd.drop = (len_plus == 2'd2);
            cmd.rel  = (len_plus == 2'd2) ? 2'd0 : len_plus;
            cmd.dump = 1'b1;
         end
      end else begin
         cmd.rel      = held;
         cmd.store_ch = 1'b1;
         cmd.dump     = final_in;
         seg_len_in   = (seg_len_ff == 2'd3) ? 2'd3 : len_plus;
         if (char_in != CH_DOT) begin
            all_dots_in = 1'b0;
         end
      end
      if (final_in) begin
         in_query_in = 1'b0;
         seg_len_in  = 2'd0;
         all_dots_in = 1'b1;
      end
   end

   assign enq = accept && has_ops(cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_query_ff <= 1'b0;
         seg_len_ff  <= 2'd0;
         all_dots_ff <= 1'b1;
      end else if (accept) begin
         in_query_ff <= in_query_in;
         seg_len_ff  <= seg_len_in;
         all_dots_ff <= all_dots_in;
      end
   end

endmodule

// File: rtl/core/upn_cmd_queue.sv
// Short command queue between the front end and the back end.
module upn_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enq,
   input  upn_pkg::cmd_type     cmd,
   output logic                 full,
   output upn_pkg::cq_head_type head,
   input  logic                 deq
);
   import upn_pkg::*;

   cmd_type               entry_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]   count_ff, count_in;
   logic                  do_deq;

   assign full      = (count_ff == CQ_CNT_W'(CQ_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd  = entry_ff[rd_ptr_ff];
   assign do_deq    = deq && head.valid;

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + CQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_deq ? rd_ptr_ff + CQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CQ_CNT_W'(enq) - CQ_CNT_W'(do_deq);
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/upn_back.sv
// Back end: path store, segment removal, path dump and the result queue.
module upn_back (
   input  logic                 clock,
   input  logic                 reset,
   input  upn_pkg::cq_head_type head,
   output logic                 deq,
   input  logic                 pop,
   output logic                 empty,
   output upn_pkg::result_type  result
);
   import upn_pkg::*;

   typedef enum logic {ST_RUN, ST_SCAN} state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic                cmd_valid_ff, cmd_valid_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                last_slash_ff, last_slash_in;
   logic                ovf_ff, ovf_in;
   logic [ADDR_W-1:0]   dump_idx_ff, dump_idx_in;
   logic                rd_push_ff, rd_push_in;
   logic                pend_last_ff, pend_last_in;
   logic                pend_fin_ff, pend_fin_in;
   logic                pend_ovf_ff, pend_ovf_in;

   logic [7:0]          path_mem [MAX_PATH];
   logic [7:0]          rdata_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [7:0]          mem_wdata;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;

   logic                store_req;
   logic [7:0]          store_byte;
   logic                finish;
   logic [FILL_W-1:0]   fill_base;
   logic [FILL_W-1:0]   fill_m1;
   logic [FILL_W-1:0]   fill_m2;
   logic [FILL_W-1:0]   base_m1;

   result_type          oq_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] oq_wr_ff, oq_wr_in;
   logic [OQ_PTR_W-1:0] oq_rd_ff, oq_rd_in;
   logic [OQ_CNT_W-1:0] oq_count_ff, oq_count_in;
   logic                op_push;
   result_type          op_res;
   logic                push_en;
   result_type          push_res;
   logic                do_pop;
   logic                oq_room;
   logic                oq_room_dump;

   assign fill_base    = fill_ff - FILL_W'(last_slash_ff);
   assign base_m1      = fill_base - FILL_W'(1);
   assign fill_m1      = fill_ff - FILL_W'(1);
   assign fill_m2      = fill_ff - FILL_W'(2);
   assign oq_room      = !rd_push_ff && (oq_count_ff < OQ_CNT_W'(OQ_DEPTH));
   assign oq_room_dump = (oq_count_ff + OQ_CNT_W'(rd_push_ff)) < OQ_CNT_W'(OQ_DEPTH);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cmd_valid_in  = cmd_valid_ff;
      fill_in       = fill_ff;
      last_slash_in = last_slash_ff;
      ovf_in        = ovf_ff;
      dump_idx_in   = dump_idx_ff;
      rd_push_in    = 1'b0;
      pend_last_in  = pend_last_ff;
      pend_fin_in   = pend_fin_ff;
      pend_ovf_in   = pend_ovf_ff;
      mem_we        = 1'b0;
      mem_waddr     = fill_ff[ADDR_W-1:0];
      mem_wdata     = CH_DOT;
      rd_en         = 1'b0;
      rd_addr       = dump_idx_ff;
      store_req     = 1'b0;
      store_byte    = CH_DOT;
      op_push       = 1'b0;
      op_res        = '0;
      deq           = 1'b0;
      finish        = 1'b0;

      if (cmd_valid_ff) begin
         if (cmd_ff.rel != 2'd0) begin
            store_req  = 1'b1;
            store_byte = CH_DOT;
            cmd_in.rel = cmd_ff.rel - 2'd1;
         end else if (cmd_ff.drop) begin
            case (state_ff)
               ST_RUN: begin
                  fill_in       = fill_base;
                  last_slash_in = 1'b0;
                  if (fill_base == '0) begin
                     cmd_in.drop = 1'b0;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = base_m1[ADDR_W-1:0];
                     state_in = ST_SCAN;
                  end
               end
               ST_SCAN: begin
                  fill_in = fill_m1;
                  if (rdata_ff == CH_SLASH || fill_m1 == '0) begin
                     cmd_in.drop = 1'b0;
                     state_in    = ST_RUN;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = fill_m2[ADDR_W-1:0];
                  end
               end
               default: begin
                  state_in = ST_RUN;
               end
            endcase
         end else if (cmd_ff.store_ch) begin
            store_req       = 1'b1;
            store_byte      = cmd_ff.ch;
            cmd_in.store_ch = 1'b0;
         end else if (cmd_ff.slash) begin
            store_req    = (fill_ff != '0) && !last_slash_ff;
            store_byte   = CH_SLASH;
            cmd_in.slash = 1'b0;
         end else if (cmd_ff.qbyte) begin
            if (oq_room) begin
               op_push           = 1'b1;
               op_res.ch         = cmd_ff.ch;
               op_res.part       = 1'b1;
               op_res.overflowed = ovf_ff;
               op_res.run_end    = 1'b1;
               op_res.target_end = cmd_ff.fin;
               cmd_in.qbyte      = 1'b0;
            end
         end else if (cmd_ff.dump) begin
            if (fill_ff == '0) begin
               if (oq_room) begin
                  op_push           = 1'b1;
                  op_res.empty_path = 1'b1;
                  op_res.overflowed = ovf_ff;
                  op_res.run_end    = 1'b1;
                  op_res.target_end = cmd_ff.fin;
                  cmd_in.dump       = 1'b0;
               end
            end else if (oq_room_dump) begin
               rd_en        = 1'b1;
               rd_addr      = dump_idx_ff;
               rd_push_in   = 1'b1;
               pend_fin_in  = cmd_ff.fin;
               pend_ovf_in  = ovf_ff;
               pend_last_in = (FILL_W'(dump_idx_ff) == fill_m1);
               if (FILL_W'(dump_idx_ff) == fill_m1) begin
                  dump_idx_in = '0;
                  cmd_in.dump = 1'b0;
               end else begin
                  dump_idx_in = dump_idx_ff + ADDR_W'(1);
               end
            end
         end
         finish = !has_ops(cmd_in);
      end

      if (store_req) begin
         if (fill_ff < FILL_W'(MAX_PATH)) begin
            mem_we        = 1'b1;
            mem_wdata     = store_byte;
            fill_in       = fill_ff + FILL_W'(1);
            last_slash_in = (store_byte == CH_SLASH);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (!cmd_valid_ff || finish) begin
         if (cmd_valid_ff && cmd_ff.fin) begin
            fill_in       = '0;
            ovf_in        = 1'b0;
            last_slash_in = 1'b0;
         end
         cmd_valid_in = head.valid;
         cmd_in       = head.cmd;
         deq          = head.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         path_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rdata_ff <= path_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         cmd_valid_ff  <= 1'b0;
         fill_ff       <= '0;
         last_slash_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         dump_idx_ff   <= '0;
         rd_push_ff    <= 1'b0;
         pend_last_ff  <= 1'b0;
         pend_fin_ff   <= 1'b0;
         pend_ovf_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmd_valid_ff  <= cmd_valid_in;
         fill_ff       <= fill_in;
         last_slash_ff <= last_slash_in;
         ovf_ff        <= ovf_in;
         dump_idx_ff   <= dump_idx_in;
         rd_push_ff    <= rd_push_in;
         pend_last_ff  <= pend_last_in;
         pend_fin_ff   <= pend_fin_in;
         pend_ovf_ff   <= pend_ovf_in;
      end
      cmd_ff <= cmd_in;
   end

   always_comb begin
      push_en  = rd_push_ff || op_push;
      push_res = op_res;
      if (rd_push_ff) begin
         push_res            = '0;
         push_res.ch         = rdata_ff;
         push_res.overflowed = pend_ovf_ff;
         push_res.run_end    = pend_last_ff;
         push_res.target_end = pend_last_ff && pend_fin_ff;
      end
   end

   assign empty  = (oq_count_ff == '0);
   assign result = oq_ff[oq_rd_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      oq_wr_in    = push_en ? oq_wr_ff + OQ_PTR_W'(1) : oq_wr_ff;
      oq_rd_in    = do_pop ? oq_rd_ff + OQ_PTR_W'(1) : oq_rd_ff;
      oq_count_in = oq_count_ff + OQ_CNT_W'(push_en) - OQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         oq_ff[oq_wr_ff] <= push_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_count_ff <= oq_count_in;
      end
   end

endmodule

// File: rtl/core/url_path_normalizer.sv
// Top level of the URL path normalizer with dot-segment removal.
//
//   Channel   Direction  Handshake       Payload
//   req_      in         push / full     req_char_in, req_final_in
//   rsp_      out        empty / pop     rsp_char_out, rsp_part, rsp_empty_path,
//                                        rsp_overflowed, rsp_run_end, rsp_target_end
//
// Ordinary path and query bytes go through at one item per cycle while the result side is not stalled.
// Each held dot that is released into the path store is written as its own store step.
// A ".." segment scans the path store backward, one stored byte per cycle.
// A path dump reads the store at one byte per cycle while the result queue has room; each byte is registered first.
// Reset is synchronous and clears control state; the path store is not cleared.
// A stalled result side fills the result queue, then the command queue, then full rises.
module url_path_normalizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_char_in,
   input  logic       req_final_in,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_char_out,
   output logic       rsp_part,
   output logic       rsp_empty_path,
   output logic       rsp_overflowed,
   output logic       rsp_run_end,
   output logic       rsp_target_end
);
   import upn_pkg::*;

   `include "url_path_normalizer_assert.svh"

   logic        q_full;
   logic        enq;
   cmd_type     cmd;
   cq_head_type head;
   logic        deq;
   result_type  result;
   logic        empty_item_ok;

   upn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .char_in  (req_char_in),
      .final_in (req_final_in),
      .q_full   (q_full),
      .full     (full),
      .enq      (enq),
      .cmd      (cmd)
   );

   upn_cmd_queue u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .enq   (enq),
      .cmd   (cmd),
      .full  (q_full),
      .head  (head),
      .deq   (deq)
   );

   upn_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .deq    (deq),
      .pop    (pop),
      .empty  (empty),
      .result (result)
   );

   assign rsp_char_out   = result.ch;
   assign rsp_part       = result.part;
   assign rsp_empty_path = result.empty_path;
   assign rsp_overflowed = result.overflowed;
   assign rsp_run_end    = result.run_end;
   assign rsp_target_end = result.target_end;

   assign empty_item_ok = !rsp_part && rsp_char_out == 8'h00;

   `UPN_ASSERT_IMPLIES(a_target_end_ends_run, clock, reset, !empty && rsp_target_end, rsp_run_end)
   `UPN_ASSERT_IMPLIES(a_empty_path_item, clock, reset, !empty && rsp_empty_path, empty_item_ok)
   `UPN_ASSERT_IMPLIES(a_query_item_ends_run, clock, reset, !empty && rsp_part, rsp_run_end)

endmodule
